/* rtl/core/cle_pkg.sv */
`timescale 1ns / 1ps
// Shared types and codes for the circular list engine.
package cle_pkg;

  typedef enum logic [2:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_AFTER = 3'd1,
    CMD_INS_BACK  = 3'd2,
    CMD_REM_FRONT = 3'd3,
    CMD_REM_KEY   = 3'd4,
    CMD_REM_BACK  = 3'd5,
    CMD_DUMP      = 3'd6,
    CMD_SEARCH    = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_NOTFOUND = 2'd1,
    STS_EMPTY    = 2'd2,
    STS_FULL     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_ALLOC,
    ST_INS_NODE,
    ST_INS_LINK,
    ST_REMOVE,
    ST_REPLY
  } state_t;

  typedef struct packed {
    cmd_t               command;
    logic signed [31:0] new_value;
    logic signed [31:0] match_key;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic               found;
    logic signed [31:0] element;
    logic [5:0]         element_total;
    logic signed [31:0] value_sum;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic scan;
    logic give;
  } alloc_ctl_t;

endpackage

/* rtl/core/cle_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module cle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/cle_slot_alloc.sv */
`timescale 1ns / 1ps
// Free-slot map with a one-bit-per-cycle scan for the lowest free slot.
module cle_slot_alloc #(
  parameter int CAPACITY = 32,
  localparam int AW = $clog2(CAPACITY)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cle_pkg::alloc_ctl_t ctl,
  input  logic [AW-1:0]       give_idx,
  output logic                hit,
  output logic [AW-1:0]       slot
);
  import cle_pkg::*;

  logic [CAPACITY-1:0] free_r, free_nxt;
  logic [AW-1:0]       scan_r, scan_nxt;

  assign hit  = ctl.scan && free_r[scan_r];
  assign slot = scan_r;

  always_comb begin
    free_nxt = free_r;
    if (hit) begin
      free_nxt[scan_r] = 1'b0;
    end
    if (ctl.give) begin
      free_nxt[give_idx] = 1'b1;
    end
    scan_nxt = (ctl.scan && !hit) ? scan_r + AW'(1) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r <= {CAPACITY{1'b1}};
      scan_r <= '0;
    end else begin
      free_r <= free_nxt;
      scan_r <= scan_nxt;
    end
  end

endmodule

/* rtl/core/circular_list_engine_top.sv */
`timescale 1ns / 1ps
// Top level of the circular list engine: sequencer, list registers and node memories.
//
//   Channel  Direction  Handshake             Payload
//   in_      input      in_valid / in_ready   cle_pkg::in_item_t (command, new_value, match_key)
//   out_     output     out_valid / out_ready cle_pkg::out_item_t (status ... last)
//
// An item is taken only in the idle state, and the block stays busy until it has
// handed its last result to the output register. The walk visits one node per cycle;
// search, keyed commands and removal at the back walk up to element_total nodes. An
// insert scans the free map one slot per cycle up to and including the lowest free one,
// then writes the node and, unless the list was empty, links it in. A dump gives one item
// per cycle while the output is taken; a stalled output holds the sequencer in place.
module circular_list_engine_top #(
  parameter int CAPACITY   = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cle_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output cle_pkg::out_item_t out_data
);
  import cle_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  state_t          state_r, state_nxt;
  cmd_t            cmd_r, cmd_nxt;
  logic [DATA_WIDTH-1:0] nv_r, nv_nxt, key_r, key_nxt, nval_r, nval_nxt;
  logic [AW-1:0]   head_r, head_nxt, tail_r, tail_nxt;
  logic [AW-1:0]   cur_r, cur_nxt, prev_r, prev_nxt, step_r, step_nxt;
  logic [AW-1:0]   slot_r, slot_nxt, nlink_r, nlink_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [31:0]     sum_r, sum_nxt;
  status_t         res_status_r, res_status_nxt;
  logic            res_found_r, res_found_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_data_r, out_data_nxt;

  // Memory ports.
  logic                  val_we, link_we;
  logic [AW-1:0]         link_waddr, link_wdata, rd_addr;
  logic [DATA_WIDTH-1:0] rd_value;
  logic [AW-1:0]         rd_link, lnk;

  // Allocator.
  alloc_ctl_t    alloc_ctl;
  logic          alloc_hit;
  logic [AW-1:0] alloc_slot;

  // Walk and emission control.
  logic in_fire, empty, full, match, at_end, slot_free, walk_adv, keyed;
  logic emit;
  out_item_t emit_item;

  // Shared operand for the running-sum add and subtract.
  logic [DATA_WIDTH-1:0] sum_opnd_dw;
  logic [63:0]           sum_opnd_64, elem_64;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign empty     = (count_r == '0);
  assign full      = (count_r == CW'(CAPACITY));
  assign slot_free = !out_valid_r || out_ready;

  // A link at or beyond the pool size reads as slot zero.
  assign lnk    = (int'(rd_link) < CAPACITY) ? rd_link : '0;
  assign match  = (rd_value == key_r);
  assign at_end = (CW'(step_r) == count_r - CW'(1));
  assign keyed  = (cmd_r == CMD_INS_AFTER) || (cmd_r == CMD_REM_KEY) ||
                  (cmd_r == CMD_SEARCH);

  always_comb begin
    walk_adv = 1'b0;
    if (state_r == ST_WALK) begin
      unique case (cmd_r)
        CMD_INS_AFTER, CMD_REM_KEY, CMD_SEARCH: walk_adv = !match && !at_end;
        CMD_REM_BACK:                           walk_adv = !at_end;
        CMD_DUMP:                               walk_adv = slot_free && !at_end;
        default:                                walk_adv = 1'b0;
      endcase
    end
  end

  assign sum_opnd_dw = (state_r == ST_INS_NODE) ? nv_r : nval_r;
  assign sum_opnd_64 = 64'($signed(sum_opnd_dw));
  assign elem_64     = 64'($signed(rd_value));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_data.command)
            CMD_INS_FRONT, CMD_INS_BACK: state_nxt = full ? ST_REPLY : ST_ALLOC;
            CMD_INS_AFTER: state_nxt = (empty || full) ? ST_REPLY : ST_WALK;
            default:       state_nxt = empty ? ST_REPLY : ST_WALK;
          endcase
        end
      end
      ST_WALK: begin
        unique case (cmd_r)
          CMD_INS_AFTER: begin
            if (match) state_nxt = ST_ALLOC;
            else if (at_end) state_nxt = ST_REPLY;
          end
          CMD_REM_KEY: begin
            if (match) state_nxt = ST_REMOVE;
            else if (at_end) state_nxt = ST_REPLY;
          end
          CMD_SEARCH: begin
            if (match || at_end) state_nxt = ST_REPLY;
          end
          CMD_REM_FRONT: state_nxt = ST_REMOVE;
          CMD_REM_BACK: begin
            if (at_end) state_nxt = ST_REMOVE;
          end
          CMD_DUMP: begin
            if (slot_free && at_end) state_nxt = ST_IDLE;
          end
          default: state_nxt = ST_REPLY;
        endcase
      end
      ST_ALLOC: begin
        if (alloc_hit) state_nxt = ST_INS_NODE;
      end
      ST_INS_NODE: state_nxt = empty ? ST_REPLY : ST_INS_LINK;
      ST_INS_LINK: state_nxt = ST_REPLY;
      ST_REMOVE:   state_nxt = ST_REPLY;
      ST_REPLY: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Memory, allocator and result control.
  always_comb begin
    val_we         = (state_r == ST_INS_NODE);
    link_we        = 1'b0;
    link_waddr     = cur_r;
    link_wdata     = slot_r;
    alloc_ctl.scan = (state_r == ST_ALLOC);
    alloc_ctl.give = (state_r == ST_REMOVE);
    unique case (state_r)
      ST_IDLE: rd_addr = head_r;
      ST_WALK: rd_addr = walk_adv ? lnk : cur_r;
      default: rd_addr = cur_r;
    endcase
    unique case (state_r)
      ST_INS_NODE: begin
        link_we    = 1'b1;
        link_waddr = slot_r;
        link_wdata = empty ? slot_r : nlink_r;
      end
      ST_INS_LINK: begin
        link_we    = 1'b1;
        link_waddr = cur_r;
        link_wdata = slot_r;
      end
      ST_REMOVE: begin
        link_we    = (count_r > CW'(1));
        link_waddr = prev_r;
        link_wdata = nlink_r;
      end
      default: link_we = 1'b0;
    endcase

    emit                    = 1'b0;
    emit_item.status        = res_status_r;
    emit_item.found         = res_found_r;
    emit_item.element       = '0;
    emit_item.element_total = 6'(count_r);
    emit_item.value_sum     = sum_r;
    emit_item.last          = 1'b1;
    if (state_r == ST_REPLY) begin
      emit = slot_free;
    end else if ((state_r == ST_WALK) && (cmd_r == CMD_DUMP)) begin
      emit              = slot_free;
      emit_item.status  = STS_OK;
      emit_item.found   = 1'b0;
      emit_item.element = elem_64[31:0];
      emit_item.last    = at_end;
    end
  end

  // Datapath register updates.
  always_comb begin
    cmd_nxt        = cmd_r;
    nv_nxt         = nv_r;
    key_nxt        = key_r;
    nval_nxt       = nval_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    step_nxt       = step_r;
    slot_nxt       = slot_r;
    nlink_nxt      = nlink_r;
    count_nxt      = count_r;
    sum_nxt        = sum_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cmd_nxt       = in_data.command;
          nv_nxt        = DATA_WIDTH'(in_data.new_value);
          key_nxt       = DATA_WIDTH'(in_data.match_key);
          step_nxt      = '0;
          prev_nxt      = tail_r;
          nlink_nxt     = head_r;
          res_found_nxt = 1'b0;
          // Front and back inserts link in between the tail and the head.
          if ((in_data.command == CMD_INS_FRONT) || (in_data.command == CMD_INS_BACK)) begin
            cur_nxt        = tail_r;
            res_status_nxt = full ? STS_FULL : STS_OK;
          end else begin
            cur_nxt = head_r;
            if (empty) begin
              res_status_nxt = STS_EMPTY;
            end else if (full && (in_data.command == CMD_INS_AFTER)) begin
              res_status_nxt = STS_FULL;
            end else begin
              res_status_nxt = STS_OK;
            end
          end
        end
      end
      ST_WALK: begin
        nval_nxt  = rd_value;
        nlink_nxt = lnk;
        if (walk_adv) begin
          prev_nxt = cur_r;
          cur_nxt  = lnk;
          step_nxt = step_r + AW'(1);
        end
        if (keyed) begin
          if (match) begin
            res_found_nxt = 1'b1;
          end else if (at_end) begin
            res_status_nxt = STS_NOTFOUND;
          end
        end
      end
      ST_ALLOC: begin
        if (alloc_hit) slot_nxt = alloc_slot;
      end
      ST_INS_NODE: begin
        count_nxt = count_r + CW'(1);
        sum_nxt   = sum_r + sum_opnd_64[31:0];
        if (empty) begin
          head_nxt = slot_r;
          tail_nxt = slot_r;
        end
      end
      ST_INS_LINK: begin
        unique case (cmd_r)
          CMD_INS_FRONT: head_nxt = slot_r;
          CMD_INS_BACK:  tail_nxt = slot_r;
          default: begin
            if (cur_r == tail_r) tail_nxt = slot_r;
          end
        endcase
      end
      ST_REMOVE: begin
        count_nxt = count_r - CW'(1);
        sum_nxt   = sum_r - sum_opnd_64[31:0];
        if (count_r == CW'(1)) begin
          head_nxt = '0;
          tail_nxt = '0;
        end else begin
          if (cur_r == head_r) head_nxt = nlink_r;
          if (cur_r == tail_r) tail_nxt = prev_r;
        end
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = emit_item;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    nv_r         <= nv_nxt;
    key_r        <= key_nxt;
    nval_r       <= nval_nxt;
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    step_r       <= step_nxt;
    slot_r       <= slot_nxt;
    nlink_r      <= nlink_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  cle_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_value_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (slot_r),
    .wdata (nv_r),
    .raddr (rd_addr),
    .rdata (rd_value)
  );

  cle_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (rd_addr),
    .rdata (rd_link)
  );

  cle_slot_alloc #(.CAPACITY(CAPACITY)) u_alloc (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (alloc_ctl),
    .give_idx (cur_r),
    .hit      (alloc_hit),
    .slot     (alloc_slot)
  );

endmodule

/* rtl/core/cle_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the circular list engine and their binding to the top level.
module cle_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input cle_pkg::out_item_t out_data
);
  import cle_pkg::*;

  // One item at a time: taking an item makes the block busy.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready stayed high after an item was taken");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == STS_EMPTY) |-> out_data.element_total == 6'd0)
    else $error("empty status with a nonzero element count");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.found |-> (out_data.status == STS_OK) && out_data.last)
    else $error("found flag on a result that is not a final ok");

endmodule

bind circular_list_engine_top cle_checker u_cle_checker (.*);

/* sim/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the circular list engine top level.
module tb;
  import cle_pkg::*;

  localparam int CAP       = 32;
  localparam int WDOG_MAX  = 20000;
  localparam int N_RANDOM  = 395;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  always #2 clk = ~clk;

  circular_list_engine_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // The list itself is kept in order in a queue, front at index 0. This
  // holds the same information as the node pool, without the links.
  logic signed [31:0] list_q[$];
  logic [31:0]        list_sum;
  out_item_t          result_q[$];
  in_item_t           cmd_q[$];

  int  n_fail = 0;
  int  n_sent = 0;
  int  n_results = 0;
  int  hist[8];
  bit  stim_done = 1'b0;
  bit  hold_sender = 1'b0;
  bit  long_hold = 1'b0;

  function automatic out_item_t mk(status_t s, logic f, logic signed [31:0] e,
                                   logic l);
    out_item_t r;
    r.status        = s;
    r.found         = f;
    r.element       = e;
    r.element_total = 6'(list_q.size());
    r.value_sum     = list_sum;
    r.last          = l;
    return r;
  endfunction

  // First position whose value equals the key, or -1.
  function automatic int locate(logic signed [31:0] key);
    foreach (list_q[i]) if (list_q[i] == key) return i;
    return -1;
  endfunction

  // Applies one command to the list model and queues the results it causes.
  task automatic apply_command(in_item_t it);
    int pos;
    bit empty;
    bit full;
    empty = (list_q.size() == 0);
    full  = (list_q.size() >= CAP);
    case (it.command)
      CMD_INS_FRONT, CMD_INS_BACK: begin
        if (full) begin
          result_q.push_back(mk(STS_FULL, 1'b0, '0, 1'b1));
        end else begin
          if (it.command == CMD_INS_FRONT) list_q.push_front(it.new_value);
          else list_q.push_back(it.new_value);
          list_sum += it.new_value;
          result_q.push_back(mk(STS_OK, 1'b0, '0, 1'b1));
        end
      end
      CMD_INS_AFTER: begin
        // The full check takes priority over the key search.
        pos = locate(it.match_key);
        if (empty) result_q.push_back(mk(STS_EMPTY, 1'b0, '0, 1'b1));
        else if (full) result_q.push_back(mk(STS_FULL, 1'b0, '0, 1'b1));
        else if (pos < 0) result_q.push_back(mk(STS_NOTFOUND, 1'b0, '0, 1'b1));
        else begin
          list_q.insert(pos + 1, it.new_value);
          list_sum += it.new_value;
          result_q.push_back(mk(STS_OK, 1'b1, '0, 1'b1));
        end
      end
      CMD_REM_FRONT, CMD_REM_BACK: begin
        if (empty) begin
          result_q.push_back(mk(STS_EMPTY, 1'b0, '0, 1'b1));
        end else begin
          if (it.command == CMD_REM_FRONT) list_sum -= list_q.pop_front();
          else list_sum -= list_q.pop_back();
          result_q.push_back(mk(STS_OK, 1'b0, '0, 1'b1));
        end
      end
      CMD_REM_KEY: begin
        pos = locate(it.match_key);
        if (empty) result_q.push_back(mk(STS_EMPTY, 1'b0, '0, 1'b1));
        else if (pos < 0) result_q.push_back(mk(STS_NOTFOUND, 1'b0, '0, 1'b1));
        else begin
          list_sum -= list_q[pos];
          list_q.delete(pos);
          result_q.push_back(mk(STS_OK, 1'b1, '0, 1'b1));
        end
      end
      CMD_DUMP: begin
        if (empty) result_q.push_back(mk(STS_EMPTY, 1'b0, '0, 1'b1));
        else foreach (list_q[i])
          result_q.push_back(mk(STS_OK, 1'b0, list_q[i], i == list_q.size() - 1));
      end
      default: begin
        pos = locate(it.match_key);
        if (empty) result_q.push_back(mk(STS_EMPTY, 1'b0, '0, 1'b1));
        else if (pos < 0) result_q.push_back(mk(STS_NOTFOUND, 1'b0, '0, 1'b1));
        else result_q.push_back(mk(STS_OK, 1'b1, '0, 1'b1));
      end
    endcase
  endtask

  function automatic in_item_t mk_cmd(cmd_t c, logic signed [31:0] v,
                                      logic signed [31:0] k);
    in_item_t it;
    it.command   = c;
    it.new_value = v;
    it.match_key = k;
    return it;
  endfunction

  // Values come from a small pool most of the time so that keys hit often.
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return $urandom();
      1:       return 32'sh7fffffff;
      2:       return 32'sh80000000;
      default: return $signed(32'($urandom_range(0, 11)) - 32'sd6);
    endcase
  endfunction

  function automatic in_item_t random_cmd(int fill_bias);
    cmd_t c;
    int   r;
    r = $urandom_range(0, 99);
    // Phases alternate between leaning toward growing and an even mix of all
    // commands so that both full and empty lists are reached.
    if (r < fill_bias) c = cmd_t'($urandom_range(0, 2));
    else c = cmd_t'($urandom_range(0, 7));
    return mk_cmd(c, pick_value(), pick_value());
  endfunction

  // Stimulus: directed items, then random phases with a directed fill among them.
  initial begin
    cmd_q.push_back(mk_cmd(CMD_DUMP,      0, 0));
    cmd_q.push_back(mk_cmd(CMD_REM_FRONT, 0, 0));
    cmd_q.push_back(mk_cmd(CMD_REM_BACK,  0, 0));
    cmd_q.push_back(mk_cmd(CMD_REM_KEY,   0, 0));
    cmd_q.push_back(mk_cmd(CMD_SEARCH,    0, 0));
    cmd_q.push_back(mk_cmd(CMD_INS_AFTER, 5, 0));
    cmd_q.push_back(mk_cmd(CMD_INS_FRONT, 32'sh7fffffff, 0));
    cmd_q.push_back(mk_cmd(CMD_INS_BACK,  32'sh80000000, 0));
    cmd_q.push_back(mk_cmd(CMD_INS_AFTER, 32'shffffffff, 32'sh80000000));
    cmd_q.push_back(mk_cmd(CMD_INS_AFTER, 7, 32'sh7fffffff));
    cmd_q.push_back(mk_cmd(CMD_INS_AFTER, 7, 12345));
    cmd_q.push_back(mk_cmd(CMD_SEARCH,    0, 32'shffffffff));
    cmd_q.push_back(mk_cmd(CMD_SEARCH,    0, 99));
    cmd_q.push_back(mk_cmd(CMD_DUMP,      0, 0));
    cmd_q.push_back(mk_cmd(CMD_REM_KEY,   0, 32'sh7fffffff));
    cmd_q.push_back(mk_cmd(CMD_REM_KEY,   0, 32'shffffffff));
    cmd_q.push_back(mk_cmd(CMD_REM_KEY,   0, 99));
    cmd_q.push_back(mk_cmd(CMD_REM_BACK,  0, 0));
    cmd_q.push_back(mk_cmd(CMD_REM_FRONT, 0, 0));
    cmd_q.push_back(mk_cmd(CMD_INS_BACK,  1, 0));
    cmd_q.push_back(mk_cmd(CMD_REM_BACK,  0, 0));
    for (int p = 0; p < N_RANDOM; p++) begin
      if (p == 40) begin
        // Fill to capacity with front and back inserts, poke at it while full,
        // then dump it whole.
        for (int i = 0; i < CAP + 1; i++)
          cmd_q.push_back(mk_cmd(($urandom_range(0, 1) != 0) ? CMD_INS_BACK : CMD_INS_FRONT,
                                 pick_value(), pick_value()));
        cmd_q.push_back(mk_cmd(CMD_INS_FRONT, 1, 0));
        cmd_q.push_back(mk_cmd(CMD_INS_AFTER, 1, 0));
        cmd_q.push_back(mk_cmd(CMD_DUMP, 0, 0));
      end
      cmd_q.push_back(random_cmd(((p / 60) % 2 == 0) ? 45 : 0));
    end
  end

  // Sender: bursts of random length with gaps between them.
  int burst_left = 0;
  int gap_left   = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        apply_command(in_data);
        hist[in_data.command]++;
        n_sent++;
      end
      if (!in_valid || in_ready) begin
        if (cmd_q.size() == 0) begin
          in_valid <= 1'b0;
          stim_done <= 1'b1;
        end else if (n_sent == 150 && !hold_sender && result_q.size() != 0) begin
          // Pause once until every outstanding result has come back.
          in_valid <= 1'b0;
        end else if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else begin
          if (n_sent == 150) hold_sender <= 1'b1;
          in_valid <= 1'b1;
          in_data  <= cmd_q.pop_front();
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 12);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // Receiver: stalls on its own pattern, with one long hold-off early on.
  int rx_cycle = 0;
  int long_cnt = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      rx_cycle <= rx_cycle + 1;
      if (!long_hold && n_sent == 60) begin
        long_hold <= 1'b1;
        long_cnt  <= 400;
        out_ready <= 1'b0;
      end else if (long_cnt > 0) begin
        long_cnt  <= long_cnt - 1;
        out_ready <= (long_cnt == 1);
      end else if ((rx_cycle / 256) % 2 == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // Monitor: checks each taken result against the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (result_q.size() == 0) begin
        $error("result with no expectation pending");
        n_fail++;
      end else begin
        want = result_q.pop_front();
        if (out_data.status !== want.status) begin
          $error("status exp %0d got %0d", want.status, out_data.status); n_fail++;
        end
        if (out_data.found !== want.found) begin
          $error("found exp %0d got %0d", want.found, out_data.found); n_fail++;
        end
        if (out_data.element !== want.element) begin
          $error("element exp %0d got %0d", want.element, out_data.element); n_fail++;
        end
        if (out_data.element_total !== want.element_total) begin
          $error("element_total exp %0d got %0d", want.element_total,
                 out_data.element_total); n_fail++;
        end
        if (out_data.value_sum !== want.value_sum) begin
          $error("value_sum exp %0d got %0d", want.value_sum, out_data.value_sum);
          n_fail++;
        end
        if (out_data.last !== want.last) begin
          $error("last exp %0d got %0d", want.last, out_data.last); n_fail++;
        end
      end
    end
  end

  // Watchdog: cycles with no item moving on either side.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("watchdog expired, %0d results pending", result_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    list_sum = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    wait (stim_done && !in_valid && result_q.size() == 0);
    repeat (100) @(posedge clk);
    $display("sent %0d commands (per code: %0d %0d %0d %0d %0d %0d %0d %0d)",
             n_sent, hist[0], hist[1], hist[2], hist[3], hist[4], hist[5],
             hist[6], hist[7]);
    $display("checked %0d results", n_results);
    if (n_fail == 0 && result_q.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
